/* design/lkfr_pkg.sv */
`default_nettype none
package lkfr_pkg;

  localparam int FRAME_TOTAL = 16;
  localparam int K_MAX       = 4;

  localparam int STAMP_W = 48;
  localparam int FID_W   = 4;
  localparam int TOT_W   = 5;
  localparam int DEPTH_W = 3;
  localparam int IDX_W   = $clog2(FRAME_TOTAL);
  localparam int CNT_W   = $clog2(K_MAX + 1);
  localparam int HEAD_W  = $clog2(K_MAX);
  localparam int SLOTS   = FRAME_TOTAL * K_MAX;
  localparam int ADDR_W  = $clog2(SLOTS);

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(2);

  typedef enum logic [1:0] {
    CMD_RECORD    = 2'd0,
    CMD_SET_EVICT = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_EVICT     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic exec;
    logic scan;
    logic finish;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic evict;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* design/lkfr_ram.sv */
`default_nettype none
module lkfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/lkfr_cmp.sv */
`default_nettype none
module lkfr_cmp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         clear,
  input  wire logic                         valid,
  input  wire logic                         full,
  input  wire logic [lkfr_pkg::IDX_W-1:0]   idx,
  input  wire logic [lkfr_pkg::STAMP_W-1:0] stamp,
  output logic                              have,
  output logic      [lkfr_pkg::IDX_W-1:0]   best_idx
);

  logic                         have_r;
  logic                         best_full_r;
  logic [lkfr_pkg::STAMP_W-1:0] best_stamp_r;
  logic [lkfr_pkg::IDX_W-1:0]   best_idx_r;
  logic                         take;

  // not-full frames beat full ones, then the older stamp, ties keep the lower id
  assign take = valid && (!have_r || (!full && best_full_r) ||
                          (full == best_full_r && stamp < best_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (clear) begin
      have_r <= 1'b0;
    end else if (take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_full_r  <= full;
      best_stamp_r <= stamp;
      best_idx_r   <= idx;
    end
  end

  assign have     = have_r;
  assign best_idx = best_idx_r;

endmodule
`default_nettype wire

/* design/lkfr_ctrl.sv */
`default_nettype none
module lkfr_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire lkfr_pkg::stat_t            stat,
  output logic                            in_ready,
  output lkfr_pkg::ctl_t                  ctl,
  output logic      [lkfr_pkg::IDX_W-1:0] scan_idx
);

  localparam logic [lkfr_pkg::IDX_W-1:0] LAST = lkfr_pkg::IDX_W'(lkfr_pkg::FRAME_TOTAL - 1);

  lkfr_pkg::state_t state_r, state_nxt;
  logic [lkfr_pkg::IDX_W-1:0] scan_r, scan_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkfr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lkfr_pkg::ST_EXEC;
      end
      lkfr_pkg::ST_EXEC: begin
        state_nxt = stat.evict ? lkfr_pkg::ST_SCAN : lkfr_pkg::ST_DONE;
      end
      lkfr_pkg::ST_SCAN: begin
        if (scan_r == LAST) state_nxt = lkfr_pkg::ST_DRAIN;
      end
      lkfr_pkg::ST_DRAIN:  state_nxt = lkfr_pkg::ST_FINISH;
      lkfr_pkg::ST_FINISH: state_nxt = lkfr_pkg::ST_DONE;
      lkfr_pkg::ST_DONE: begin
        if (stat.out_free) state_nxt = lkfr_pkg::ST_IDLE;
      end
      default: state_nxt = lkfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctl          = '0;
    scan_nxt     = scan_r;
    case (state_r)
      lkfr_pkg::ST_IDLE: in_ready = 1'b1;
      lkfr_pkg::ST_EXEC: begin
        ctl.exec = 1'b1;
        scan_nxt = '0;
      end
      lkfr_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
        scan_nxt = scan_r + 1'b1;
      end
      lkfr_pkg::ST_FINISH: ctl.finish = 1'b1;
      lkfr_pkg::ST_DONE:   ctl.load_out = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkfr_pkg::ST_IDLE;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign scan_idx = scan_r;

endmodule
`default_nettype wire

/* design/lru_k_frame_replacer.sv */
`default_nettype none
// channel | ports                                                | direction
// in      | in_valid in_ready in_cmd in_frame_id in_make_evictable | item in
// out     | out_valid out_ready out_victim_found out_victim_frame   | item out
//         | out_evictable_count                                  |
// cfg     | cfg_valid cfg_ready cfg_history_depth                | register write
//
// record, set-evictable and remove: executed, then the result is loaded; one item at a time
// evict: executed, then scan over every frame, drain and finish, then the result is loaded
// one stamp memory read per frame feeds the shared compare unit, then drain and retire
// synchronous active-low reset clears frame flags, rings, the stamp counter and depth (k = 2)
// a result held by out_ready keeps the block from finishing the next item; cfg is always ready
module lru_k_frame_replacer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_cmd,
  input  wire logic [lkfr_pkg::FID_W-1:0]     in_frame_id,
  input  wire logic                           in_make_evictable,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_victim_found,
  output logic      [lkfr_pkg::FID_W-1:0]     out_victim_frame,
  output logic      [lkfr_pkg::TOT_W-1:0]     out_evictable_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lkfr_pkg::DEPTH_W-1:0]   cfg_history_depth
);

  lkfr_pkg::ctl_t  ctl;
  lkfr_pkg::stat_t stat;
  logic [lkfr_pkg::IDX_W-1:0] scan_idx;

  logic [lkfr_pkg::DEPTH_W-1:0] depth_r;
  lkfr_pkg::cmd_t               cmd_r;
  logic [lkfr_pkg::FID_W-1:0]   fid_r;
  logic                         mk_r;

  logic [lkfr_pkg::FRAME_TOTAL-1:0] present_r;
  logic [lkfr_pkg::FRAME_TOTAL-1:0] evict_r;
  logic [lkfr_pkg::CNT_W-1:0]       count_r [lkfr_pkg::FRAME_TOTAL];
  logic [lkfr_pkg::HEAD_W-1:0]      head_r  [lkfr_pkg::FRAME_TOTAL];
  logic [lkfr_pkg::STAMP_W-1:0]     stamp_r;
  logic [lkfr_pkg::TOT_W-1:0]       total_r;

  logic                         p_valid_r;
  logic                         p_elig_r;
  logic                         p_full_r;
  logic [lkfr_pkg::IDX_W-1:0]   p_idx_r;

  logic                         res_found_r;
  logic [lkfr_pkg::FID_W-1:0]   res_victim_r;
  logic                         out_valid_r;
  logic                         out_found_r;
  logic [lkfr_pkg::FID_W-1:0]   out_victim_r;
  logic [lkfr_pkg::TOT_W-1:0]   out_count_r;

  logic [lkfr_pkg::CNT_W-1:0]   k;
  logic                         fid_ok;
  logic [lkfr_pkg::IDX_W-1:0]   sel_idx;
  logic                         sel_present;
  logic                         sel_evict;
  logic [lkfr_pkg::CNT_W-1:0]   sel_cnt;
  logic [lkfr_pkg::HEAD_W-1:0]  sel_head;
  logic [lkfr_pkg::CNT_W-1:0]   cur_cnt;
  logic [lkfr_pkg::HEAD_W-1:0]  cur_head;
  logic [lkfr_pkg::CNT_W-1:0]   rec_base;
  logic [lkfr_pkg::HEAD_W-1:0]  rec_head;
  logic [lkfr_pkg::HEAD_W-1:0]  rec_slot;
  logic [lkfr_pkg::CNT_W-1:0]   rank_off;
  logic [lkfr_pkg::HEAD_W-1:0]  rank_slot;
  logic                         sel_full;
  logic                         rec_we;
  logic [lkfr_pkg::ADDR_W-1:0]  raddr;
  logic [lkfr_pkg::STAMP_W-1:0] rdata;
  logic                         have;
  logic [lkfr_pkg::IDX_W-1:0]   best_idx;

  lkfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl),
    .scan_idx (scan_idx)
  );

  assign stat.evict    = (cmd_r == lkfr_pkg::CMD_EVICT);
  assign stat.out_free = !out_valid_r || out_ready;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= lkfr_pkg::DEPTH_RESET;
    end else if (cfg_valid) begin
      depth_r <= cfg_history_depth;
    end
  end

  always_comb begin
    if (depth_r == '0) begin
      k = lkfr_pkg::CNT_W'(1);
    end else if (32'(depth_r) > lkfr_pkg::K_MAX) begin
      k = lkfr_pkg::CNT_W'(lkfr_pkg::K_MAX);
    end else begin
      k = lkfr_pkg::CNT_W'(depth_r);
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= lkfr_pkg::cmd_t'(in_cmd);
      fid_r <= in_frame_id;
      mk_r  <= in_make_evictable;
    end
  end

  assign fid_ok  = 32'(fid_r) < lkfr_pkg::FRAME_TOTAL;
  assign sel_idx = ctl.scan ? scan_idx : fid_r[lkfr_pkg::IDX_W-1:0];

  assign sel_present = present_r[sel_idx];
  assign sel_evict   = evict_r[sel_idx];
  assign sel_cnt     = count_r[sel_idx];
  assign sel_head    = head_r[sel_idx];
  assign sel_full    = sel_cnt >= k;

  // ring update for a recorded access
  always_comb begin
    cur_cnt  = sel_present ? sel_cnt : '0;
    cur_head = sel_present ? sel_head : '0;
    if (cur_cnt >= k) begin
      rec_head = lkfr_pkg::HEAD_W'(lkfr_pkg::CNT_W'(cur_head) + (cur_cnt - k + 1'b1));
      rec_base = k - 1'b1;
    end else begin
      rec_head = cur_head;
      rec_base = cur_cnt;
    end
    rec_slot = lkfr_pkg::HEAD_W'(lkfr_pkg::CNT_W'(rec_head) + rec_base);
  end

  // slot holding the ranking stamp
  always_comb begin
    rank_off  = sel_full ? (sel_cnt - k) : '0;
    rank_slot = lkfr_pkg::HEAD_W'(lkfr_pkg::CNT_W'(sel_head) + rank_off);
  end

  assign rec_we = ctl.exec && (cmd_r == lkfr_pkg::CMD_RECORD) && fid_ok;
  assign raddr  = {sel_idx, rank_slot};

  lkfr_ram #(
    .WIDTH (lkfr_pkg::STAMP_W),
    .DEPTH (lkfr_pkg::SLOTS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr ({fid_r[lkfr_pkg::IDX_W-1:0], rec_slot}),
    .wdata (stamp_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // scan pipe, lines up with the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= ctl.scan;
    end
  end

  always_ff @(posedge clk) begin
    p_elig_r <= sel_present && sel_evict;
    p_full_r <= sel_full;
    p_idx_r  <= sel_idx;
  end

  lkfr_cmp u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (ctl.exec),
    .valid    (p_valid_r && p_elig_r),
    .full     (p_full_r),
    .idx      (p_idx_r),
    .stamp    (rdata),
    .have     (have),
    .best_idx (best_idx)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      evict_r   <= '0;
      stamp_r   <= '0;
      total_r   <= '0;
      for (int i = 0; i < lkfr_pkg::FRAME_TOTAL; i++) begin
        count_r[i] <= '0;
        head_r[i]  <= '0;
      end
    end else if (ctl.exec && fid_ok) begin
      case (cmd_r)
        lkfr_pkg::CMD_RECORD: begin
          if (!sel_present) begin
            evict_r[sel_idx] <= 1'b0;
          end
          present_r[sel_idx] <= 1'b1;
          head_r[sel_idx]    <= rec_head;
          count_r[sel_idx]   <= rec_base + 1'b1;
          stamp_r            <= stamp_r + 1'b1;
        end
        lkfr_pkg::CMD_SET_EVICT: begin
          if (sel_present) begin
            if (!sel_evict && mk_r) begin
              total_r <= total_r + 1'b1;
            end else if (sel_evict && !mk_r) begin
              total_r <= total_r - 1'b1;
            end
            evict_r[sel_idx] <= mk_r;
          end
        end
        lkfr_pkg::CMD_REMOVE: begin
          if (sel_present && sel_evict) begin
            present_r[sel_idx] <= 1'b0;
            evict_r[sel_idx]   <= 1'b0;
            count_r[sel_idx]   <= '0;
            head_r[sel_idx]    <= '0;
            total_r            <= total_r - 1'b1;
          end
        end
        default: ;
      endcase
    end else if (ctl.finish && have) begin
      present_r[best_idx] <= 1'b0;
      evict_r[best_idx]   <= 1'b0;
      count_r[best_idx]   <= '0;
      head_r[best_idx]    <= '0;
      total_r             <= total_r - 1'b1;
    end
  end

  // result and output register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_found_r  <= 1'b0;
      res_victim_r <= '0;
    end else if (ctl.finish) begin
      res_found_r  <= have;
      res_victim_r <= have ? lkfr_pkg::FID_W'(best_idx) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_found_r  <= res_found_r;
      out_victim_r <= res_victim_r;
      out_count_r  <= total_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_victim_found    = out_found_r;
  assign out_victim_frame    = out_victim_r;
  assign out_evictable_count = out_count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) == $countones(evict_r))
    else $error("evictable total out of step with flags");

  assert property (@(posedge clk) disable iff (!rst_n)
    (evict_r & ~present_r) == '0)
    else $error("evictable flag on untracked frame");

  assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.finish && have) |-> (present_r[best_idx] && evict_r[best_idx]))
    else $error("victim not an evictable frame");

endmodule
`default_nettype wire

/* verif/lru_k_checker.sv */
`timescale 1ns / 1ps
module lru_k_checker
  import lkfr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [FID_W-1:0]   in_frame_id,
  input  wire logic               in_make_evictable,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               out_victim_found,
  input  wire logic [FID_W-1:0]   out_victim_frame,
  input  wire logic [TOT_W-1:0]   out_evictable_count,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [DEPTH_W-1:0] cfg_history_depth,
  output int                      mismatch_count,
  output int                      reports_owed
);

  typedef struct packed {
    logic             found;
    logic [FID_W-1:0] frame;
    logic [TOT_W-1:0] count;
  } report_t;

  logic [STAMP_W-1:0] stamps    [FRAME_TOTAL][K_MAX];
  logic [CNT_W-1:0]   hist_cnt  [FRAME_TOTAL];
  logic [HEAD_W-1:0]  hist_head [FRAME_TOTAL];
  logic               tracked   [FRAME_TOTAL];
  logic               evictable [FRAME_TOTAL];
  logic [STAMP_W-1:0] stamp_clock;
  logic [TOT_W-1:0]   evictable_total;
  logic [DEPTH_W-1:0] depth_reg;
  report_t            victim_reports [$];
  int                 errors;

  function automatic int depth_k();
    if (depth_reg < 1) return 1;
    if (depth_reg > K_MAX) return K_MAX;
    return int'(depth_reg);
  endfunction

  function automatic void drop_frame(int f);
    tracked[f] = 1'b0;
    evictable[f] = 1'b0;
    hist_cnt[f] = '0;
    hist_head[f] = '0;
    evictable_total = evictable_total - 1'b1;
  endfunction

  function automatic report_t run_command(cmd_t c, int f, logic mk);
    report_t            rep;
    int                 k, cnt, head, off, best;
    logic               have, full, best_full;
    logic [STAMP_W-1:0] s, best_stamp;
    rep = '0;
    k = depth_k();
    case (c)
      CMD_RECORD: begin
        cnt = hist_cnt[f];
        head = hist_head[f];
        if (!tracked[f]) begin
          tracked[f] = 1'b1;
          evictable[f] = 1'b0;
          cnt = 0;
          head = 0;
        end
        // keep only the newest k stamps, counting the one added now
        if (cnt >= k) begin
          head = (head + cnt - k + 1) % K_MAX;
          cnt = k - 1;
        end
        stamps[f][(head + cnt) % K_MAX] = stamp_clock;
        hist_cnt[f] = CNT_W'(cnt + 1);
        hist_head[f] = HEAD_W'(head);
        stamp_clock = stamp_clock + 1'b1;
      end
      CMD_SET_EVICT: begin
        if (tracked[f]) begin
          if (!evictable[f] && mk) evictable_total = evictable_total + 1'b1;
          else if (evictable[f] && !mk) evictable_total = evictable_total - 1'b1;
          evictable[f] = mk;
        end
      end
      CMD_REMOVE: begin
        if (tracked[f] && evictable[f]) drop_frame(f);
      end
      default: begin
        have = 1'b0;
        best_full = 1'b0;
        best_stamp = '0;
        best = 0;
        for (int i = 0; i < FRAME_TOTAL; i++) begin
          if (!tracked[i] || !evictable[i]) continue;
          // frames short of k stamps beat full ones, then oldest stamp wins
          full = (hist_cnt[i] >= k);
          off = full ? (hist_cnt[i] - k) : 0;
          s = stamps[i][(hist_head[i] + off) % K_MAX];
          if (!have || (!full && best_full) || (full == best_full && s < best_stamp)) begin
            have = 1'b1;
            best = i;
            best_full = full;
            best_stamp = s;
          end
        end
        if (have) begin
          drop_frame(best);
          rep.found = 1'b1;
          rep.frame = FID_W'(best);
        end
      end
    endcase
    rep.count = evictable_total;
    return rep;
  endfunction

  always @(posedge clk) begin
    report_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_TOTAL; i++) begin
        hist_cnt[i] = '0;
        hist_head[i] = '0;
        tracked[i] = 1'b0;
        evictable[i] = 1'b0;
      end
      stamp_clock = '0;
      evictable_total = '0;
      depth_reg = DEPTH_RESET;
      victim_reports.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) depth_reg = cfg_history_depth;
      if (out_valid && out_ready) begin
        if (victim_reports.size() == 0) begin
          $error("result item with no command outstanding");
          errors++;
        end else begin
          want = victim_reports.pop_front();
          if (out_victim_found !== want.found) begin
            $error("victim_found: expected %0d, got %0d", want.found, out_victim_found);
            errors++;
          end
          if (out_victim_frame !== want.frame) begin
            $error("victim_frame: expected %0d, got %0d", want.frame, out_victim_frame);
            errors++;
          end
          if (out_evictable_count !== want.count) begin
            $error("evictable_count: expected %0d, got %0d", want.count,
                   out_evictable_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        victim_reports.push_back(run_command(cmd_t'(in_cmd), int'(in_frame_id),
                                             in_make_evictable));
      end
    end
    mismatch_count <= errors;
    reports_owed <= victim_reports.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import lkfr_pkg::*;

  localparam int STALL_LIMIT     = 3000;
  localparam int ITEMS_PER_PHASE = 160;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_cmd;
  logic [FID_W-1:0]   in_frame_id;
  logic               in_make_evictable;
  logic               out_valid;
  logic               out_ready;
  logic               out_victim_found;
  logic [FID_W-1:0]   out_victim_frame;
  logic [TOT_W-1:0]   out_evictable_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [DEPTH_W-1:0] cfg_history_depth;
  int                 mismatch_count;
  int                 reports_owed;
  int                 idle_cycles = 0;
  bit                 no_gaps = 1'b0;

  lru_k_frame_replacer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_frame_id         (in_frame_id),
    .in_make_evictable   (in_make_evictable),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_victim_found    (out_victim_found),
    .out_victim_frame    (out_victim_frame),
    .out_evictable_count (out_evictable_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_history_depth   (cfg_history_depth)
  );

  lru_k_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_frame_id         (in_frame_id),
    .in_make_evictable   (in_make_evictable),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_victim_found    (out_victim_found),
    .out_victim_frame    (out_victim_frame),
    .out_evictable_count (out_evictable_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_history_depth   (cfg_history_depth),
    .mismatch_count      (mismatch_count),
    .reports_owed        (reports_owed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input cmd_t c, input logic [FID_W-1:0] f, input logic mk);
    int r, gap;
    gap = 0;
    if (!no_gaps) begin
      r = $urandom_range(0, 99);
      gap = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_frame_id <= f;
    in_make_evictable <= mk;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_depth(input logic [DEPTH_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_history_depth <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: ready runs broken by stalls, now and then a long open stretch
  initial begin
    int r, run, stall;
    out_ready <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      run = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      stall = (r < 60) ? $urandom_range(1, 2) : (r < 92) ? $urandom_range(3, 6) :
              $urandom_range(10, 40);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  initial begin
    logic [DEPTH_W-1:0] depth_plan [8];
    logic [FID_W-1:0]   fid;
    int                 r, base;
    bit                 narrow;
    depth_plan = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd4};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_RECORD;
    in_frame_id <= '0;
    in_make_evictable <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_history_depth <= DEPTH_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner cases at the reset depth
    send_item(CMD_EVICT, 4'd0, 1'b0);
    send_item(CMD_SET_EVICT, 4'd3, 1'b1);
    send_item(CMD_REMOVE, 4'd5, 1'b0);
    send_item(CMD_RECORD, 4'd0, 1'b0);
    send_item(CMD_RECORD, 4'd15, 1'b1);
    send_item(CMD_RECORD, 4'd0, 1'b0);
    send_item(CMD_REMOVE, 4'd0, 1'b1);
    send_item(CMD_SET_EVICT, 4'd0, 1'b0);
    send_item(CMD_SET_EVICT, 4'd0, 1'b1);
    send_item(CMD_SET_EVICT, 4'd15, 1'b1);
    send_item(CMD_SET_EVICT, 4'd15, 1'b1);
    send_item(CMD_EVICT, 4'd15, 1'b1);
    send_item(CMD_RECORD, 4'd7, 1'b0);
    send_item(CMD_RECORD, 4'd7, 1'b0);
    send_item(CMD_RECORD, 4'd7, 1'b0);
    send_item(CMD_SET_EVICT, 4'd7, 1'b1);
    send_item(CMD_EVICT, 4'd0, 1'b0);
    send_item(CMD_SET_EVICT, 4'd7, 1'b0);
    send_item(CMD_SET_EVICT, 4'd7, 1'b1);
    send_item(CMD_REMOVE, 4'd7, 1'b0);
    send_item(CMD_EVICT, 4'd0, 1'b0);
    send_item(CMD_RECORD, 4'd15, 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      write_depth(depth_plan[p]);
      no_gaps = (p % 3 == 2);
      narrow = $urandom_range(0, 1);
      base = $urandom_range(0, 10);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        fid = narrow ? FID_W'(base + $urandom_range(0, 5)) :
                       FID_W'($urandom_range(0, FRAME_TOTAL - 1));
        if (r < 40) send_item(CMD_RECORD, fid, 1'($urandom_range(0, 1)));
        else if (r < 70) send_item(CMD_SET_EVICT, fid, $urandom_range(0, 3) != 0);
        else if (r < 80) send_item(CMD_REMOVE, fid, 1'($urandom_range(0, 1)));
        else send_item(CMD_EVICT, fid, 1'($urandom_range(0, 1)));
      end
    end

    no_gaps = 1'b0;
    drain_results();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
